// File: sv/modular_exponentiation_defines.svh
// assertion macros shared by the modular exponentiation checker
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// antecedent in this cycle, consequent in the next
`define MEXP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("modexp check failed");

// antecedent and consequent in the same cycle
`define MEXP_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("modexp check failed");

`endif

// File: sv/mexp_pkg.sv
// types, codes and microcode program of the modular exponentiation block
package mexp_pkg;

   localparam int MSG_W       = 32;
   localparam int RESULT_W    = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int STEP_W      = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PUBLIC_EXP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIVATE_EXP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS     = 2'd2;

   // program step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RED_GO   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RED_WAIT = 4'd3;
   localparam logic [STEP_W-1:0] STEP_INIT     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_SQR_GO   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SQR_WAIT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_TEST     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MUL_GO   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_WAIT = 4'd9;
   localparam logic [STEP_W-1:0] STEP_NEXT     = 4'd10;
   localparam logic [STEP_W-1:0] STEP_LOOP     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_DONE     = 4'd12;
   localparam logic [STEP_W-1:0] STEP_FAULT    = 4'd13;

   typedef struct packed {
      logic             op;
      logic [MSG_W-1:0] message;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result_value;
      logic                modulus_error;
   } rsp_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_NO_REQ,
      C_MZERO,
      C_MUL_BUSY,
      C_EBIT_CLR,
      C_CNT_ZERO,
      C_OUT_BLOCKED
   } cond_type;

   typedef enum logic [1:0] {
      A_ONE,
      A_BASE,
      A_ACC
   } a_sel_type;

   typedef enum logic {
      B_MSG,
      B_ACC
   } b_sel_type;

   typedef enum logic [1:0] {
      D_NONE,
      D_BASE,
      D_ACC
   } dst_type;

   // actions fire only when the step falls through (jump not taken)
   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
      logic              load_req;
      logic              mul_start;
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      dst_type           dst;
      logic              acc_one;
      logic              load_cnt;
      logic              dec_cnt;
      logic              emit;
      logic              error;
   } ucode_type;

   typedef struct packed {
      logic valid;
      logic error;
   } emit_type;

   function automatic ucode_type mexp_rom(input logic [STEP_W-1:0] step);
      ucode_type uw;
      uw = ucode_type'('0);
      case (step)
         STEP_IDLE: begin
            uw.cond     = C_NO_REQ;
            uw.target   = STEP_IDLE;
            uw.load_req = 1'b1;
         end
         STEP_CHECK: begin
            uw.cond   = C_MZERO;
            uw.target = STEP_FAULT;
         end
         // base = message mod n, as (1 mod n) * message
         STEP_RED_GO: begin
            uw.mul_start = 1'b1;
            uw.a_sel     = A_ONE;
            uw.b_sel     = B_MSG;
         end
         STEP_RED_WAIT: begin
            uw.cond   = C_MUL_BUSY;
            uw.target = STEP_RED_WAIT;
            uw.dst    = D_BASE;
         end
         STEP_INIT: begin
            uw.acc_one  = 1'b1;
            uw.load_cnt = 1'b1;
         end
         STEP_SQR_GO: begin
            uw.mul_start = 1'b1;
            uw.a_sel     = A_ACC;
            uw.b_sel     = B_ACC;
         end
         STEP_SQR_WAIT: begin
            uw.cond   = C_MUL_BUSY;
            uw.target = STEP_SQR_WAIT;
            uw.dst    = D_ACC;
         end
         STEP_TEST: begin
            uw.cond   = C_EBIT_CLR;
            uw.target = STEP_NEXT;
         end
         STEP_MUL_GO: begin
            uw.mul_start = 1'b1;
            uw.a_sel     = A_BASE;
            uw.b_sel     = B_ACC;
         end
         STEP_MUL_WAIT: begin
            uw.cond   = C_MUL_BUSY;
            uw.target = STEP_MUL_WAIT;
            uw.dst    = D_ACC;
         end
         STEP_NEXT: begin
            uw.cond    = C_CNT_ZERO;
            uw.target  = STEP_DONE;
            uw.dec_cnt = 1'b1;
         end
         STEP_LOOP: begin
            uw.cond   = C_ALWAYS;
            uw.target = STEP_SQR_GO;
         end
         STEP_DONE: begin
            uw.cond   = C_OUT_BLOCKED;
            uw.target = STEP_DONE;
            uw.emit   = 1'b1;
            uw.last   = 1'b1;
         end
         STEP_FAULT: begin
            uw.cond   = C_OUT_BLOCKED;
            uw.target = STEP_FAULT;
            uw.emit   = 1'b1;
            uw.error  = 1'b1;
            uw.last   = 1'b1;
         end
         default: begin
            uw.cond   = C_ALWAYS;
            uw.target = STEP_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

// File: sv/mexp_mulser.sv
// bit-serial modular multiplier, one multiplier bit per cycle
module mexp_mulser #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] a,
   input  logic [WORD_WIDTH-1:0] b,
   input  logic [WORD_WIDTH-1:0] m,
   output logic                  busy,
   output logic [WORD_WIDTH-1:0] product
);
   import mexp_pkg::*;

   localparam int CNT_W = $clog2(WORD_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0] a_ff, a_in;
   logic [WORD_WIDTH-1:0] b_ff, b_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] dbl;
   logic [WORD_WIDTH-1:0] step;

   // (x + y) mod m for x, y below m, carry kept in the extra bit
   function automatic logic [WORD_WIDTH-1:0] add_mod(input logic [WORD_WIDTH-1:0] x,
                                                     input logic [WORD_WIDTH-1:0] y,
                                                     input logic [WORD_WIDTH-1:0] md);
      logic [WORD_WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, md}) begin
         s = s - {1'b0, md};
      end
      return s[WORD_WIDTH-1:0];
   endfunction

   always_comb begin
      dbl  = add_mod(acc_ff, acc_ff, m);
      step = b_ff[WORD_WIDTH-1] ? add_mod(dbl, a_ff, m) : dbl;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_WIDTH);
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = step;
         b_in   = {b_ff[WORD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

// File: sv/mexp_seq.sv
// microcoded sequencer and operand registers for square-and-multiply
module mexp_seq #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mexp_pkg::req_type     req_data,
   input  logic [WORD_WIDTH-1:0] public_exponent,
   input  logic [WORD_WIDTH-1:0] private_exponent,
   input  logic [WORD_WIDTH-1:0] modulus,
   input  logic                  out_blocked,
   output mexp_pkg::emit_type    emit,
   output logic [WORD_WIDTH-1:0] result,
   output logic                  mul_start,
   output logic [WORD_WIDTH-1:0] mul_a,
   output logic [WORD_WIDTH-1:0] mul_b,
   input  logic                  mul_busy,
   input  logic [WORD_WIDTH-1:0] mul_product
);
   import mexp_pkg::*;

   localparam int CNT_W = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
   localparam int EXT_W = MSG_W + WORD_WIDTH;

   logic [STEP_W-1:0]     pc_ff, pc_in;
   logic                  op_ff, op_in;
   logic [WORD_WIDTH-1:0] msg_ff, msg_in;
   logic [WORD_WIDTH-1:0] base_ff, base_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   ucode_type             uw;
   logic                  taken;
   logic                  fire;
   logic [WORD_WIDTH-1:0] one_mod;
   logic [WORD_WIDTH-1:0] expo;
   logic [EXT_W-1:0]      msg_ext;

   assign uw      = mexp_rom(pc_ff);
   assign one_mod = (modulus == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
   assign expo    = op_ff ? private_exponent : public_exponent;
   assign msg_ext = {{WORD_WIDTH{1'b0}}, req_data.message};

   always_comb begin
      case (uw.cond)
         C_NONE:        taken = 1'b0;
         C_ALWAYS:      taken = 1'b1;
         C_NO_REQ:      taken = !req_valid;
         C_MZERO:       taken = (modulus == '0);
         C_MUL_BUSY:    taken = mul_busy;
         C_EBIT_CLR:    taken = !expo[cnt_ff];
         C_CNT_ZERO:    taken = (cnt_ff == '0);
         C_OUT_BLOCKED: taken = out_blocked;
         default:       taken = 1'b1;
      endcase
   end

   assign fire = !taken;

   always_comb begin
      case (uw.a_sel)
         A_ONE:   mul_a = one_mod;
         A_BASE:  mul_a = base_ff;
         A_ACC:   mul_a = acc_ff;
         default: mul_a = one_mod;
      endcase
      mul_b = (uw.b_sel == B_MSG) ? msg_ff : acc_ff;
   end

   always_comb begin
      if (taken) begin
         pc_in = uw.target;
      end else if (uw.last) begin
         pc_in = STEP_IDLE;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end

      op_in   = op_ff;
      msg_in  = msg_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;

      if (fire && uw.load_req) begin
         op_in  = req_data.op;
         msg_in = msg_ext[WORD_WIDTH-1:0];
      end
      if (fire && uw.dst == D_BASE) begin
         base_in = mul_product;
      end
      if (fire && uw.dst == D_ACC) begin
         acc_in = mul_product;
      end
      if (fire && uw.acc_one) begin
         acc_in = one_mod;
      end
      if (fire && uw.load_cnt) begin
         cnt_in = CNT_W'(WORD_WIDTH - 1);
      end
      if (fire && uw.dec_cnt) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
      op_ff   <= op_in;
      msg_ff  <= msg_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
   end

   assign req_stall  = (pc_ff != STEP_IDLE);
   assign mul_start  = uw.mul_start;
   assign emit.valid = fire && uw.emit;
   assign emit.error = uw.error;
   assign result     = acc_ff;

endmodule

// File: sv/modular_exponentiation.sv
// Modular exponentiation core: each request word gives result = message ^ e mod n, with e
// the public exponent (op 0) or the private exponent (op 1) and n the modulus, all taken
// from the control registers (index 0 public exponent, 1 private exponent, 2 modulus).
// A zero modulus returns 0 with modulus_error set; a zero exponent returns 1 mod n.
// One request is worked on at a time. A small microcode program walks the exponent from
// its top bit down, squaring and, where the bit is set, multiplying, on one bit-serial
// modular multiplier that handles one multiplier bit per cycle. A finished word waits in an
// output register, and the next request is taken as soon as it has been handed over to it.
module modular_exponentiation #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mexp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mexp_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]            csr_data
);
   import mexp_pkg::*;

   localparam int EXT_W = RESULT_W + WORD_WIDTH;

   logic [WORD_WIDTH-1:0] pub_exp_ff, pub_exp_in;
   logic [WORD_WIDTH-1:0] priv_exp_ff, priv_exp_in;
   logic [WORD_WIDTH-1:0] modulus_ff, modulus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   emit_type              emit;
   logic [WORD_WIDTH-1:0] result;
   logic [EXT_W-1:0]      result_ext;
   logic                  out_blocked;
   logic                  mul_start;
   logic [WORD_WIDTH-1:0] mul_a;
   logic [WORD_WIDTH-1:0] mul_b;
   logic                  mul_busy;
   logic [WORD_WIDTH-1:0] mul_product;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign result_ext  = {{RESULT_W{1'b0}}, result};

   mexp_seq #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .public_exponent  (pub_exp_ff),
      .private_exponent (priv_exp_ff),
      .modulus          (modulus_ff),
      .out_blocked      (out_blocked),
      .emit             (emit),
      .result           (result),
      .mul_start        (mul_start),
      .mul_a            (mul_a),
      .mul_b            (mul_b),
      .mul_busy         (mul_busy),
      .mul_product      (mul_product)
   );

   mexp_mulser #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .m       (modulus_ff),
      .busy    (mul_busy),
      .product (mul_product)
   );

   always_comb begin
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      modulus_in  = modulus_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PUBLIC_EXP:  pub_exp_in  = csr_data;
            CSR_PRIVATE_EXP: priv_exp_in = csr_data;
            CSR_MODULUS:     modulus_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.modulus_error = emit.error;
         rsp_data_in.result_value  = emit.error ? '0 : result_ext[RESULT_W-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_exp_ff   <= '0;
         priv_exp_ff  <= '0;
         modulus_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pub_exp_ff   <= pub_exp_in;
         priv_exp_ff  <= priv_exp_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/mexp_checker.sv
// port-level checks for the modular exponentiation core, bound to the top level
`include "modular_exponentiation_defines.svh"

module mexp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mexp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mexp_pkg::rsp_type rsp_data
);
   import mexp_pkg::*;

   // a stalled result word holds
   `MEXP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // an error word always carries a zero result
   `MEXP_ASSERT_SAME(a_err_zero, rsp_valid && rsp_data.modulus_error, rsp_data.result_value == '0)

   // once a request is taken the core is busy in the next cycle
   `MEXP_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

// File: tb/tb_modular_exponentiation.sv
// testbench for the modular exponentiation core: keyed words checked against a local predictor
module tb_modular_exponentiation;
   timeunit 1ns;
   timeprecision 1ps;

   import mexp_pkg::*;

   localparam int WIDTH         = 32;
   localparam int ITEMS_PER_KEY = 22;
   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [WIDTH-1:0]       csr_data  = '0;

   // local copy of the key registers
   logic [WIDTH-1:0] pub_exp  = '0;
   logic [WIDTH-1:0] priv_exp = '0;
   logic [WIDTH-1:0] mod_n    = '0;

   rsp_type     pending_powers[$];
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          fail_count    = 0;
   int          words_sent    = 0;
   int          words_checked = 0;
   int          key_count     = 0;
   int          fault_words   = 0;
   int          unit_words    = 0;
   int unsigned cycle_count   = 0;

   modular_exponentiation #(
      .WORD_WIDTH(WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL modular_exponentiation");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // message ^ exponent mod n, reduced after every multiply
   function automatic rsp_type power_mod(input req_type w);
      rsp_type          r;
      logic [63:0]      acc;
      logic [63:0]      base;
      logic [63:0]      m;
      logic [WIDTH-1:0] e;
      r = '0;
      e = w.op ? priv_exp : pub_exp;
      if (mod_n == '0) begin
         r.modulus_error = 1'b1;
         return r;
      end
      m    = {32'd0, mod_n};
      base = {32'd0, w.message} % m;
      acc  = 64'd1 % m;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (e[i])
            acc = (acc * base) % m;
      end
      r.result_value = acc[WIDTH-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_powers.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               $error("result_value expected %h actual %h", want.result_value,
                  rsp_data.result_value);
               fail_count++;
            end
            if (rsp_data.modulus_error !== want.modulus_error) begin
               $error("modulus_error expected %b actual %b", want.modulus_error,
                  rsp_data.modulus_error);
               fail_count++;
            end
            words_checked++;
         end
      end
   end

   task automatic send_word(input logic op, input logic [WIDTH-1:0] msg);
      req_type w;
      int      gap;
      w.op      = op;
      w.message = msg;
      gap       = 0;
      // now and then a long gap, so requests land at any point of the block's work
      if (send_idle_pct != 0 && $urandom_range(0, 9) == 0)
         gap = $urandom_range(1, 2400);
      else
         while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      pending_powers.push_back(power_mod(w));
      words_sent++;
      if (mod_n == '0)
         fault_words++;
      else if ((op ? priv_exp : pub_exp) == '0)
         unit_words++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic load_key(input logic [WIDTH-1:0] pub_v, input logic [WIDTH-1:0] priv_v,
                           input logic [WIDTH-1:0] mod_v);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= CSR_PUBLIC_EXP;
      csr_data  <= pub_v;
      @(posedge clock);
      pub_exp = pub_v;
      csr_index <= CSR_PRIVATE_EXP;
      csr_data  <= priv_v;
      @(posedge clock);
      priv_exp = priv_v;
      csr_index <= CSR_MODULUS;
      csr_data  <= mod_v;
      @(posedge clock);
      mod_n = mod_v;
      csr_write <= 1'b0;
      key_count++;
   endtask

   function automatic logic [WIDTH-1:0] pick_exponent();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return 32'd65537;
         3:       return $urandom_range(1, 15);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WIDTH-1:0] pick_modulus();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return $urandom_range(2, 255);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WIDTH-1:0] pick_message();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return mod_n - 1;
         4:       return mod_n;
         5:       return $urandom_range(0, mod_n);
         default: return $urandom();
      endcase
   endfunction

   // registers come out of reset as zero, so the first words hit the zero-modulus path
   task automatic test_reset_state();
      send_word(1'b0, 32'h1234_5678);
      send_word(1'b1, '1);
   endtask

   // textbook key n = 61 * 53, e = 17, d = 2753
   task automatic test_small_key();
      load_key(32'd17, 32'd2753, 32'd3233);
      send_word(1'b0, 32'd65);
      send_word(1'b1, 32'd2790);
      send_word(1'b0, '0);
      send_word(1'b1, 32'd3232);
      send_word(1'b0, 32'd3233);
      send_word(1'b1, '1);
   endtask

   task automatic test_extremes();
      load_key('1, '1, '1);
      send_word(1'b0, '1);
      send_word(1'b1, 32'hFFFF_FFFE);
      send_word(1'b0, 32'd1);
      load_key('1, 32'h8000_0000, 32'hFFFF_FFFB);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b1, 32'h7FFF_FFFF);
      // modulus of one: everything collapses to zero
      load_key('1, '0, 32'd1);
      send_word(1'b0, '1);
      send_word(1'b1, 32'd7);
   endtask

   task automatic test_zero_exponent();
      load_key('0, '0, 32'hDEAD_BEEF);
      send_word(1'b0, 32'h0BAD_F00D);
      send_word(1'b1, '0);
   endtask

   task automatic test_zero_modulus();
      load_key(32'd3, 32'd5, '0);
      send_word(1'b0, 32'd2);
      send_word(1'b1, '1);
   endtask

   // a write to the spare index must leave the key alone
   task automatic test_spare_index();
      load_key(32'd3, 32'hFFFF_0001, 32'hC000_0003);
      csr_write <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_data  <= '1;
      @(posedge clock);
      csr_data  <= $urandom();
      @(posedge clock);
      csr_write <= 1'b0;
      send_word(1'b0, 32'h1357_9BDF);
      send_word(1'b1, 32'hFEDC_BA98);
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct);
      drain_results();
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (3) begin
         load_key(pick_exponent(), pick_exponent(), pick_modulus());
         repeat (ITEMS_PER_KEY) send_word(1'($urandom_range(0, 1)), pick_message());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_small_key();
      test_extremes();
      test_zero_exponent();
      test_zero_modulus();
      test_spare_index();
      test_random_traffic(0, 0);
      test_random_traffic(63, 0);
      test_random_traffic(0, 63);
      test_random_traffic(16, 16);

      drain_results();
      repeat (64) @(posedge clock);

      $display("checked %0d of %0d words over %0d key settings", words_checked, words_sent,
         key_count);
      $display("%0d words with zero modulus, %0d with zero exponent", fault_words, unit_words);
      if (fail_count == 0)
         $display("PASS modular_exponentiation");
      else
         $display("FAIL modular_exponentiation");
      $finish;
   end

endmodule
